### hdl/mdg_pkg.sv
// Shared types, codes and helper functions of the maze generator.
package mdg_pkg;

    // Field widths fixed by the request and result formats
    localparam int POS_W      = 5;
    localparam int GRID_W     = 6;
    localparam int SEED_W     = 16;
    localparam int PERM_W     = 5;
    localparam int TRIES_W    = 3;
    localparam int PASS_W     = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Reset values of the configuration registers and of the LFSR, and the LFSR taps
    localparam logic [GRID_W-1:0] GRID_ROWS_RESET = 6'd32;
    localparam logic [GRID_W-1:0] GRID_COLS_RESET = 6'd32;
    localparam logic [SEED_W-1:0] SEED_RESET      = 16'd44257;
    localparam logic [SEED_W-1:0] LFSR_TAPS       = 16'hB400;

    // All four directions of a frame have been tried
    localparam logic [TRIES_W-1:0] TRIES_DONE = 3'd4;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROWS = 2'd0,
        CFG_COLS = 2'd1,
        CFG_SEED = 2'd2
    } cfg_reg_t;

    // Request kinds
    typedef enum logic {
        REQ_GEN  = 1'b0,
        REQ_READ = 1'b1
    } req_kind_t;

    // Walk directions
    typedef enum logic [1:0] {
        DIR_U = 2'd0,
        DIR_D = 2'd1,
        DIR_L = 2'd2,
        DIR_R = 2'd3
    } dir_t;

    // Try order of one cell: element 0 is tried first
    typedef dir_t [3:0] order_t;

    // Controller states
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_ENTER,
        ST_STEP,
        ST_CHECK,
        ST_POP,
        ST_ENT_RD,
        ST_ENT_WR
    } state_t;

    // Request payload
    typedef struct packed {
        logic             req_type;
        logic [POS_W-1:0] pos_col;
        logic [POS_W-1:0] pos_row;
    } req_t;

    // Result payload
    typedef struct packed {
        logic open_up;
        logic open_down;
        logic open_left;
        logic open_right;
        logic status;
    } res_t;

    // One grid memory word: visited mark and passages (up, down, left, right from bit 0)
    typedef struct packed {
        logic              visited;
        logic [PASS_W-1:0] pass;
    } cell_t;

    // Control from the walk sequencer to the shuffle unit
    typedef struct packed {
        logic load;
        logic advance;
    } rng_ctrl_t;

    // Lexicographic permutation k of up, down, left, right
    function automatic order_t perm_order(input logic [PERM_W-1:0] k);
        order_t ord;
        unique case (k)
            5'd0:    ord = {DIR_R, DIR_L, DIR_D, DIR_U};
            5'd1:    ord = {DIR_L, DIR_R, DIR_D, DIR_U};
            5'd2:    ord = {DIR_R, DIR_D, DIR_L, DIR_U};
            5'd3:    ord = {DIR_D, DIR_R, DIR_L, DIR_U};
            5'd4:    ord = {DIR_L, DIR_D, DIR_R, DIR_U};
            5'd5:    ord = {DIR_D, DIR_L, DIR_R, DIR_U};
            5'd6:    ord = {DIR_R, DIR_L, DIR_U, DIR_D};
            5'd7:    ord = {DIR_L, DIR_R, DIR_U, DIR_D};
            5'd8:    ord = {DIR_R, DIR_U, DIR_L, DIR_D};
            5'd9:    ord = {DIR_U, DIR_R, DIR_L, DIR_D};
            5'd10:   ord = {DIR_L, DIR_U, DIR_R, DIR_D};
            5'd11:   ord = {DIR_U, DIR_L, DIR_R, DIR_D};
            5'd12:   ord = {DIR_R, DIR_D, DIR_U, DIR_L};
            5'd13:   ord = {DIR_D, DIR_R, DIR_U, DIR_L};
            5'd14:   ord = {DIR_R, DIR_U, DIR_D, DIR_L};
            5'd15:   ord = {DIR_U, DIR_R, DIR_D, DIR_L};
            5'd16:   ord = {DIR_D, DIR_U, DIR_R, DIR_L};
            5'd17:   ord = {DIR_U, DIR_D, DIR_R, DIR_L};
            5'd18:   ord = {DIR_L, DIR_D, DIR_U, DIR_R};
            5'd19:   ord = {DIR_D, DIR_L, DIR_U, DIR_R};
            5'd20:   ord = {DIR_L, DIR_U, DIR_D, DIR_R};
            5'd21:   ord = {DIR_U, DIR_L, DIR_D, DIR_R};
            5'd22:   ord = {DIR_D, DIR_U, DIR_L, DIR_R};
            5'd23:   ord = {DIR_U, DIR_D, DIR_L, DIR_R};
            default: ord = {DIR_R, DIR_L, DIR_D, DIR_U};
        endcase
        return ord;
    endfunction

    // Passage bit of a direction
    function automatic logic [PASS_W-1:0] dir_bit(input dir_t d);
        logic [PASS_W-1:0] b;
        unique case (d)
            DIR_U: b = 4'b0001;
            DIR_D: b = 4'b0010;
            DIR_L: b = 4'b0100;
            DIR_R: b = 4'b1000;
        endcase
        return b;
    endfunction

    // Direction pointing back
    function automatic dir_t dir_opposite(input dir_t d);
        dir_t o;
        unique case (d)
            DIR_U: o = DIR_D;
            DIR_D: o = DIR_U;
            DIR_L: o = DIR_R;
            DIR_R: o = DIR_L;
        endcase
        return o;
    endfunction

    // One step of the Galois LFSR, right shift
    function automatic logic [SEED_W-1:0] lfsr_step(input logic [SEED_W-1:0] x);
        return {1'b0, x[SEED_W-1:1]} ^ (x[0] ? LFSR_TAPS : '0);
    endfunction

endpackage

### hdl/mdg_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
module mdg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write one entry, read one entry into the output register
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### hdl/mdg_shuffle.sv
// LFSR and try-order selection: advanced LFSR value mod 24 gives the permutation number.
module mdg_shuffle (
    input  logic                         clk,
    input  logic                         rst_n,
    input  mdg_pkg::rng_ctrl_t           ctrl,
    input  logic [mdg_pkg::SEED_W-1:0]   seed,
    output logic [mdg_pkg::PERM_W-1:0]   perm_k
);

    logic [mdg_pkg::SEED_W-1:0] lfsr_reg;
    logic [mdg_pkg::SEED_W-1:0] lfsr_next;
    logic [mdg_pkg::SEED_W-1:0] lfsr_adv;
    logic [12:0]                hi;
    logic [29:0]                prod;
    logic [12:0]                quot;
    logic [12:0]                rem3;

    assign lfsr_adv = mdg_pkg::lfsr_step(lfsr_reg);

    // Split mod 24 into the low three bits and a mod 3 of the rest
    assign hi   = lfsr_adv[15:3];
    assign prod = 30'(hi) * 30'(17'h0AAAB);
    assign quot = prod[29:17];
    assign rem3 = hi - {quot[11:0], 1'b0} - quot;

    assign perm_k = {rem3[1:0], lfsr_adv[2:0]};

    // Load the seed at generate, step once per entered cell
    always_comb
    begin
        lfsr_next = lfsr_reg;
        if (ctrl.load)
        begin
            lfsr_next = seed;
        end
        else if (ctrl.advance)
        begin
            lfsr_next = lfsr_adv;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lfsr_reg <= mdg_pkg::SEED_RESET;
        end
        else
        begin
            lfsr_reg <= lfsr_next;
        end
    end

endmodule

### hdl/maze_dfs_generator_unit.sv
// Maze generator top level: depth-first walk over a grid memory with an explicit frame stack.
//
// A request is taken when start is high and busy is low; its result shows on result for
// exactly one cycle with done high and cannot be held off. After reset the block sweeps the
// grid memory to zero, one cell a cycle, with busy high; configuration writes are taken
// during that sweep. A position outside the grid gives its result in the cycle after the
// request; a read passes through ST_READ, which registers the grid memory data as the result.
// A generate first sweeps the whole grid memory, then walks: a direction that leaves the grid
// is settled in ST_STEP alone, one that needs the visited lookup in the grid memory goes on to
// ST_CHECK, and each backtrack goes through ST_POP for the stack memory read; the last frame
// ends in ST_ENT_RD and ST_ENT_WR, which open the entrance and give the result. The user must
// see that configuration is written only while the block is idle; the block does not enforce it.
module maze_dfs_generator_unit #(
    parameter int MAX_ROWS = 32,
    parameter int MAX_COLS = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  mdg_pkg::req_t                     request,
    output logic                              busy,
    output logic                              done,
    output mdg_pkg::res_t                     result,
    input  logic                              cfg_we,
    input  logic [mdg_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [mdg_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int CELLS = MAX_ROWS * MAX_COLS;
    localparam int AW    = $clog2(CELLS);
    localparam int DW    = $clog2(CELLS + 1);
    localparam int RW    = $clog2(MAX_ROWS);
    localparam int CW    = $clog2(MAX_COLS);
    localparam int RU    = $clog2(MAX_ROWS + 1);
    localparam int CU    = $clog2(MAX_COLS + 1);
    localparam int RUW   = (RU > mdg_pkg::GRID_W) ? RU : mdg_pkg::GRID_W;
    localparam int CUW   = (CU > mdg_pkg::GRID_W) ? CU : mdg_pkg::GRID_W;
    localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);

    // One stack frame: cell, try order, tries done, passages opened so far
    typedef struct packed {
        logic [RW-1:0]               row;
        logic [CW-1:0]               col;
        logic [mdg_pkg::PERM_W-1:0]  perm;
        logic [mdg_pkg::TRIES_W-1:0] tries;
        logic [mdg_pkg::PASS_W-1:0]  pass;
    } frame_t;

    localparam int FW = $bits(frame_t);

    mdg_pkg::state_t             state_reg, state_next;
    logic [AW-1:0]               clr_reg, clr_next;
    logic                        gen_reg, gen_next;
    logic [DW-1:0]               depth_reg, depth_next;
    logic                        done_reg, done_next;
    mdg_pkg::res_t               result_reg, result_next;
    frame_t                      top_reg, top_next;
    logic [RW-1:0]               st_row_reg, st_row_next;
    logic [CW-1:0]               st_col_reg, st_col_next;
    logic [RW-1:0]               nb_row_reg, nb_row_next;
    logic [CW-1:0]               nb_col_reg, nb_col_next;
    mdg_pkg::dir_t               nb_dir_reg, nb_dir_next;
    logic [mdg_pkg::GRID_W-1:0]  rows_reg, cols_reg;
    logic [mdg_pkg::SEED_W-1:0]  seed_reg;

    logic [RUW-1:0]              rows_wide, rows_used;
    logic [CUW-1:0]              cols_wide, cols_used;
    logic                        in_range;
    logic [RW-1:0]               req_row;
    logic [CW-1:0]               req_col;
    logic [CW-1:0]               ent_col;
    logic [DW-1:0]               depth_m1, depth_m2;

    mdg_pkg::order_t             cur_order;
    mdg_pkg::dir_t               cur_dir;
    logic                        nb_ok;
    logic [RW-1:0]               nb_row;
    logic [CW-1:0]               nb_col;

    logic                        cell_we;
    logic [AW-1:0]               cell_waddr, cell_raddr;
    mdg_pkg::cell_t              cell_wdata, cell_rdata;
    logic                        stk_we;
    logic [AW-1:0]               stk_waddr, stk_raddr;
    frame_t                      stk_wdata, stk_rdata;

    mdg_pkg::rng_ctrl_t          rng_ctrl;
    logic [mdg_pkg::PERM_W-1:0]  perm_k;

    // Row-major address of a cell
    function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] r, input logic [CW-1:0] c);
        return AW'(r) * AW'(MAX_COLS) + AW'(c);
    endfunction

    // Grid memory: visited mark and passages per cell
    mdg_ram #(
        .WIDTH ($bits(mdg_pkg::cell_t)),
        .DEPTH (CELLS)
    ) u_grid_ram (
        .clk   (clk),
        .we    (cell_we),
        .waddr (cell_waddr),
        .wdata (cell_wdata),
        .raddr (cell_raddr),
        .rdata (cell_rdata)
    );

    // Stack memory: frames below the top frame
    mdg_ram #(
        .WIDTH (FW),
        .DEPTH (CELLS)
    ) u_stack_ram (
        .clk   (clk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    mdg_shuffle u_shuffle (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (rng_ctrl),
        .seed   (seed_reg),
        .perm_k (perm_k)
    );

    // Clamp the grid size to the memory size
    assign rows_wide = RUW'(rows_reg);
    assign cols_wide = CUW'(cols_reg);
    assign rows_used = (rows_wide > RUW'(MAX_ROWS)) ? RUW'(MAX_ROWS) : rows_wide;
    assign cols_used = (cols_wide > CUW'(MAX_COLS)) ? CUW'(MAX_COLS) : cols_wide;

    assign in_range = (RUW'(request.pos_row) < rows_used) && (CUW'(request.pos_col) < cols_used);
    assign req_row  = RW'(request.pos_row);
    assign req_col  = CW'(request.pos_col);
    assign ent_col  = CW'(cols_used >> 1);
    assign depth_m1 = depth_reg - DW'(1);
    assign depth_m2 = depth_reg - DW'(2);

    // Next direction of the top frame and its neighbor
    assign cur_order = mdg_pkg::perm_order(top_reg.perm);
    assign cur_dir   = cur_order[top_reg.tries[1:0]];

    always_comb
    begin
        nb_row = top_reg.row;
        nb_col = top_reg.col;
        unique case (cur_dir)
            mdg_pkg::DIR_U:
            begin
                nb_ok  = (top_reg.row != '0);
                nb_row = top_reg.row - RW'(1);
            end
            mdg_pkg::DIR_D:
            begin
                nb_ok  = ((RUW'(top_reg.row) + RUW'(1)) < rows_used);
                nb_row = top_reg.row + RW'(1);
            end
            mdg_pkg::DIR_L:
            begin
                nb_ok  = (top_reg.col != '0);
                nb_col = top_reg.col - CW'(1);
            end
            mdg_pkg::DIR_R:
            begin
                nb_ok  = ((CUW'(top_reg.col) + CUW'(1)) < cols_used);
                nb_col = top_reg.col + CW'(1);
            end
        endcase
    end

    // Sequencer: next state, memory accesses, result
    always_comb
    begin
        state_next  = state_reg;
        clr_next    = clr_reg;
        gen_next    = gen_reg;
        depth_next  = depth_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        top_next    = top_reg;
        st_row_next = st_row_reg;
        st_col_next = st_col_reg;
        nb_row_next = nb_row_reg;
        nb_col_next = nb_col_reg;
        nb_dir_next = nb_dir_reg;
        cell_we     = 1'b0;
        cell_waddr  = cell_addr(top_reg.row, top_reg.col);
        cell_wdata  = '0;
        cell_raddr  = cell_addr(req_row, req_col);
        stk_we      = 1'b0;
        stk_waddr   = depth_m1[AW-1:0];
        stk_wdata   = top_reg;
        stk_raddr   = depth_m2[AW-1:0];
        rng_ctrl    = '0;

        unique case (state_reg)
            // Sweep the grid memory to zero
            mdg_pkg::ST_CLEAR:
            begin
                cell_we    = 1'b1;
                cell_waddr = clr_reg;
                clr_next   = clr_reg + AW'(1);
                if (clr_reg == LAST_CELL)
                begin
                    clr_next   = '0;
                    state_next = gen_reg ? mdg_pkg::ST_ENTER : mdg_pkg::ST_IDLE;
                end
            end

            // Take a request
            mdg_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    if (!in_range)
                    begin
                        done_next          = 1'b1;
                        result_next        = '0;
                        result_next.status = 1'b1;
                    end
                    else if (request.req_type == mdg_pkg::REQ_READ)
                    begin
                        state_next = mdg_pkg::ST_READ;
                    end
                    else
                    begin
                        gen_next      = 1'b1;
                        st_row_next   = req_row;
                        st_col_next   = req_col;
                        rng_ctrl.load = 1'b1;
                        clr_next      = '0;
                        state_next    = mdg_pkg::ST_CLEAR;
                    end
                end
            end

            // Return the passages of the cell read
            mdg_pkg::ST_READ:
            begin
                done_next              = 1'b1;
                result_next.open_up    = cell_rdata.pass[0];
                result_next.open_down  = cell_rdata.pass[1];
                result_next.open_left  = cell_rdata.pass[2];
                result_next.open_right = cell_rdata.pass[3];
                result_next.status     = 1'b0;
                state_next             = mdg_pkg::ST_IDLE;
            end

            // Enter the start cell
            mdg_pkg::ST_ENTER:
            begin
                cell_we            = 1'b1;
                cell_waddr         = cell_addr(st_row_reg, st_col_reg);
                cell_wdata.visited = 1'b1;
                rng_ctrl.advance   = 1'b1;
                top_next.row       = st_row_reg;
                top_next.col       = st_col_reg;
                top_next.perm      = perm_k;
                top_next.tries     = '0;
                top_next.pass      = '0;
                depth_next         = DW'(1);
                gen_next           = 1'b0;
                state_next         = mdg_pkg::ST_STEP;
            end

            // Try the next direction, or drop the finished frame
            mdg_pkg::ST_STEP:
            begin
                if (top_reg.tries == mdg_pkg::TRIES_DONE)
                begin
                    cell_we            = 1'b1;
                    cell_wdata.visited = 1'b1;
                    cell_wdata.pass    = top_reg.pass;
                    depth_next         = depth_m1;
                    if (depth_reg == DW'(1))
                    begin
                        state_next = mdg_pkg::ST_ENT_RD;
                    end
                    else
                    begin
                        state_next = mdg_pkg::ST_POP;
                    end
                end
                else
                begin
                    top_next.tries = top_reg.tries + mdg_pkg::TRIES_W'(1);
                    if (nb_ok)
                    begin
                        cell_raddr  = cell_addr(nb_row, nb_col);
                        nb_row_next = nb_row;
                        nb_col_next = nb_col;
                        nb_dir_next = cur_dir;
                        state_next  = mdg_pkg::ST_CHECK;
                    end
                end
            end

            // Open and enter an unvisited neighbor, push the current frame
            mdg_pkg::ST_CHECK:
            begin
                if (!cell_rdata.visited)
                begin
                    stk_we             = 1'b1;
                    stk_wdata.pass     = top_reg.pass | mdg_pkg::dir_bit(nb_dir_reg);
                    cell_we            = 1'b1;
                    cell_waddr         = cell_addr(nb_row_reg, nb_col_reg);
                    cell_wdata.visited = 1'b1;
                    cell_wdata.pass    = mdg_pkg::dir_bit(mdg_pkg::dir_opposite(nb_dir_reg));
                    rng_ctrl.advance   = 1'b1;
                    top_next.row       = nb_row_reg;
                    top_next.col       = nb_col_reg;
                    top_next.perm      = perm_k;
                    top_next.tries     = '0;
                    top_next.pass      = mdg_pkg::dir_bit(mdg_pkg::dir_opposite(nb_dir_reg));
                    depth_next         = depth_reg + DW'(1);
                end
                state_next = mdg_pkg::ST_STEP;
            end

            // Restore the frame below from the stack
            mdg_pkg::ST_POP:
            begin
                top_next   = stk_rdata;
                state_next = mdg_pkg::ST_STEP;
            end

            // Read the entrance cell
            mdg_pkg::ST_ENT_RD:
            begin
                cell_raddr = AW'(ent_col);
                state_next = mdg_pkg::ST_ENT_WR;
            end

            // Open the entrance and finish the generate
            mdg_pkg::ST_ENT_WR:
            begin
                cell_we         = 1'b1;
                cell_waddr      = AW'(ent_col);
                cell_wdata      = cell_rdata;
                cell_wdata.pass = cell_rdata.pass | mdg_pkg::dir_bit(mdg_pkg::DIR_U);
                done_next       = 1'b1;
                result_next     = '0;
                state_next      = mdg_pkg::ST_IDLE;
            end

            default:
            begin
                state_next = mdg_pkg::ST_IDLE;
            end
        endcase
    end

    // Control state and configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mdg_pkg::ST_CLEAR;
            clr_reg   <= '0;
            gen_reg   <= 1'b0;
            depth_reg <= '0;
            done_reg  <= 1'b0;
            rows_reg  <= mdg_pkg::GRID_ROWS_RESET;
            cols_reg  <= mdg_pkg::GRID_COLS_RESET;
            seed_reg  <= mdg_pkg::SEED_RESET;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            gen_reg   <= gen_next;
            depth_reg <= depth_next;
            done_reg  <= done_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    mdg_pkg::CFG_ROWS: rows_reg <= cfg_data[mdg_pkg::GRID_W-1:0];
                    mdg_pkg::CFG_COLS: cols_reg <= cfg_data[mdg_pkg::GRID_W-1:0];
                    mdg_pkg::CFG_SEED: seed_reg <= cfg_data[mdg_pkg::SEED_W-1:0];
                    default:           ;
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
        top_reg    <= top_next;
        st_row_reg <= st_row_next;
        st_col_reg <= st_col_next;
        nb_row_reg <= nb_row_next;
        nb_col_reg <= nb_col_next;
        nb_dir_reg <= nb_dir_next;
    end

    assign busy   = (state_reg != mdg_pkg::ST_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

endmodule

### hdl/mdg_checker.sv
// Port-level checks of the maze generator and their binding to the top level.
module mdg_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          start,
    input logic          busy,
    input logic          done,
    input mdg_pkg::req_t request,
    input mdg_pkg::res_t result
);

    logic pend_gen_reg;
    logic any_open;

    assign any_open = result.open_up || result.open_down || result.open_left || result.open_right;

    // Track the kind of the last accepted request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_gen_reg <= 1'b0;
        end
        else if (start && !busy)
        begin
            pend_gen_reg <= (request.req_type == mdg_pkg::REQ_GEN);
        end
    end

    // An accepted request either starts work or answers at once
    a_accept_moves: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy || done)
        else $error("accepted request neither started work nor answered");

    // A result is shown only once the block is back to idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while still busy");

    // A rejected position carries no passages
    a_reject_clean: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.status |-> !any_open)
        else $error("rejected request returned passages");

    // A generate answers with no passages
    a_gen_clean: assert property (@(posedge clk) disable iff (!rst_n)
        done && pend_gen_reg |-> !any_open)
        else $error("generate returned passages");

endmodule

bind maze_dfs_generator_unit mdg_checker u_mdg_checker (.*);

### bench/mdg_checker.sv
// Maze generator checker: mirrors the depth-first walk and compares every result.
module mdg_scoreboard
    import mdg_pkg::*;
#(
    parameter int MAX_ROWS = 32,
    parameter int MAX_COLS = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic                  busy,
    input  req_t                  request,
    input  logic                  done,
    input  res_t                  result,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    pending,
    output int                    errors
);

    localparam int CELLS = MAX_ROWS * MAX_COLS;

    // One level of the walk: cell, its try order and how many directions were tried
    typedef struct packed {
        logic [POS_W-1:0]   row;
        logic [POS_W-1:0]   col;
        order_t             order;
        logic [TRIES_W-1:0] tried;
    } frame_t;

    logic [GRID_W-1:0] rows_q;
    logic [GRID_W-1:0] cols_q;
    logic [SEED_W-1:0] seed_q;
    logic [SEED_W-1:0] rng_q;
    logic [PASS_W-1:0] passages [CELLS];
    logic              visited  [CELLS];
    frame_t            frames   [CELLS];
    int unsigned       depth;
    res_t              answers [$];

    // Names of the result bits, indexed by bit position
    string field_names [5] = '{"status", "open_right", "open_left", "open_down", "open_up"};

    // Build try order number k of up, down, left, right in lexicographic ranking
    function automatic order_t order_from_rank(input int unsigned k);
        dir_t        pool [4];
        int unsigned weight [4];
        order_t      ord;
        int unsigned left;
        int unsigned pick;
        pool   = '{DIR_U, DIR_D, DIR_L, DIR_R};
        weight = '{6, 2, 1, 1};
        left   = 4;
        for (int i = 0; i < 4; i++)
        begin
            pick   = k / weight[i];
            k      = k % weight[i];
            ord[i] = pool[pick];
            for (int j = pick; j + 1 < left; j++)
                pool[j] = pool[j + 1];
            left--;
        end
        return ord;
    endfunction

    // Wipe passages and visit marks
    function automatic void clear_grid();
        for (int i = 0; i < CELLS; i++)
        begin
            passages[i] = '0;
            visited[i]  = 1'b0;
        end
    endfunction

    // Mark a cell, advance the LFSR and push its frame
    function automatic void enter_cell(input int unsigned row, input int unsigned col);
        visited[row * MAX_COLS + col] = 1'b1;
        if (rng_q[0])
            rng_q = (rng_q >> 1) ^ LFSR_TAPS;
        else
            rng_q = rng_q >> 1;
        frames[depth] = '{row: row[POS_W-1:0], col: col[POS_W-1:0],
                          order: order_from_rank(rng_q % 24), tried: '0};
        depth++;
    endfunction

    // Carve a fresh maze from the start cell, then open the entrance
    function automatic void carve_maze(input int unsigned row0, input int unsigned col0,
                                       input int unsigned rows, input int unsigned cols);
        frame_t            f;
        int unsigned       r;
        int unsigned       c;
        int unsigned       nr;
        int unsigned       nc;
        logic [PASS_W-1:0] here_bit;
        logic [PASS_W-1:0] there_bit;
        logic              ok;
        clear_grid();
        depth = 0;
        rng_q = seed_q;
        enter_cell(row0, col0);
        while (depth > 0)
        begin
            f = frames[depth - 1];
            if (f.tried == TRIES_DONE)
            begin
                depth--;
            end
            else
            begin
                frames[depth - 1].tried = f.tried + 1'b1;
                r         = f.row;
                c         = f.col;
                nr        = r;
                nc        = c;
                ok        = 1'b0;
                here_bit  = '0;
                there_bit = '0;
                case (f.order[f.tried])
                    DIR_U:
                    begin
                        ok = (r != 0);
                        nr = r - 1;
                        here_bit  = 4'b0001;
                        there_bit = 4'b0010;
                    end
                    DIR_D:
                    begin
                        ok = (r + 1 < rows);
                        nr = r + 1;
                        here_bit  = 4'b0010;
                        there_bit = 4'b0001;
                    end
                    DIR_L:
                    begin
                        ok = (c != 0);
                        nc = c - 1;
                        here_bit  = 4'b0100;
                        there_bit = 4'b1000;
                    end
                    DIR_R:
                    begin
                        ok = (c + 1 < cols);
                        nc = c + 1;
                        here_bit  = 4'b1000;
                        there_bit = 4'b0100;
                    end
                endcase
                if (ok && !visited[nr * MAX_COLS + nc])
                begin
                    passages[r * MAX_COLS + c]   |= here_bit;
                    passages[nr * MAX_COLS + nc] |= there_bit;
                    enter_cell(nr, nc);
                end
            end
        end
        passages[cols / 2][0] = 1'b1;
    endfunction

    // Work out the result of one request and update the mirrored grid
    function automatic res_t answer_request(input req_t req);
        res_t        ans;
        int unsigned rows;
        int unsigned cols;
        int unsigned idx;
        ans  = '0;
        rows = (rows_q < MAX_ROWS) ? rows_q : MAX_ROWS;
        cols = (cols_q < MAX_COLS) ? cols_q : MAX_COLS;
        if (req.pos_row >= rows || req.pos_col >= cols)
        begin
            ans.status = 1'b1;
        end
        else if (req.req_type == REQ_GEN)
        begin
            carve_maze(req.pos_row, req.pos_col, rows, cols);
        end
        else
        begin
            idx = req.pos_row * MAX_COLS + req.pos_col;
            {ans.open_right, ans.open_left, ans.open_down, ans.open_up} = passages[idx];
        end
        return ans;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        res_t want;
        if (!rst_n)
        begin
            rows_q = GRID_ROWS_RESET;
            cols_q = GRID_COLS_RESET;
            seed_q = SEED_RESET;
            rng_q  = SEED_RESET;
            clear_grid();
            depth  = 0;
            answers.delete();
            pending = 0;
            errors  = 0;
        end
        else
        begin
            // Match a result against the oldest outstanding request
            if (done)
            begin
                if (answers.size() == 0)
                begin
                    $error("result %b with no request outstanding", result);
                    errors++;
                end
                else
                begin
                    want = answers.pop_front();
                    for (int i = 0; i < 5; i++)
                    begin
                        if (result[i] !== want[i])
                        begin
                            $error("%s: expected %0b, got %0b", field_names[i], want[i],
                                   result[i]);
                            errors++;
                        end
                    end
                end
            end
            // Mirror register writes
            if (cfg_we)
            begin
                case (cfg_reg_t'(cfg_index))
                    CFG_ROWS: rows_q = cfg_data[GRID_W-1:0];
                    CFG_COLS: cols_q = cfg_data[GRID_W-1:0];
                    CFG_SEED: seed_q = cfg_data[SEED_W-1:0];
                    default: ;
                endcase
            end
            // Predict the answer of an accepted request
            if (start && !busy)
                answers = {answers, answer_request(request)};
            pending = answers.size();
        end
    end

endmodule

### bench/tb.sv
// Maze generator testbench top: reset, register settings, request stimulus and verdict.
module tb;

    import mdg_pkg::*;

    localparam int GRID_MAX = 32;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  start     = 1'b0;
    req_t                  request   = '0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  busy;
    logic                  done;
    res_t                  result;
    int                    pending;
    int                    errors;

    // Grid size in use, to aim positions inside it
    int unsigned rows_now = GRID_MAX;
    int unsigned cols_now = GRID_MAX;

    always #4 clk = ~clk;

    maze_dfs_generator_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .request   (request),
        .busy      (busy),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    mdg_scoreboard u_check (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .request   (request),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pending   (pending),
        .errors    (errors)
    );

    // Mostly back to back or short gaps, now and then a long one
    function automatic int unsigned idle_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Coordinate inside the grid, or anywhere when the grid is empty
    function automatic int unsigned pick_coord(input int unsigned limit);
        if (limit == 0)
            return $urandom_range(0, 31);
        return $urandom_range(0, limit - 1);
    endfunction

    // Mostly small grids; a few single, full-size or oversized, empty or mid-sized ones
    function automatic logic [GRID_W-1:0] pick_size();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return GRID_W'($urandom_range(2, 8));
        if (r < 80)
            return GRID_W'(1);
        if (r < 88)
            return GRID_W'($urandom_range(32, 63));
        if (r < 94)
            return GRID_W'(0);
        return GRID_W'($urandom_range(9, 31));
    endfunction

    function automatic logic [SEED_W-1:0] pick_seed();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return '0;
        if (r < 20)
            return '1;
        return SEED_W'($urandom_range(1, 65535));
    endfunction

    // Hold a request until the block takes it
    task automatic send(input req_kind_t kind, input int unsigned row, input int unsigned col);
        int unsigned gap;
        gap = idle_gap();
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start   <= 1'b1;
        request <= '{req_type: kind, pos_col: col[POS_W-1:0], pos_row: row[POS_W-1:0]};
        do
            @(posedge clk);
        while (busy);
    endtask

    // Drop start and wait until every result is back and the block is idle
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0 || busy)
            @(posedge clk);
    endtask

    // Write all three registers, with junk above the grid size bits
    task automatic write_regs(input logic [GRID_W-1:0] rows, input logic [GRID_W-1:0] cols,
                              input logic [SEED_W-1:0] seed);
        drain();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_ROWS;
        cfg_data  <= {10'($urandom_range(0, 1023)), rows};
        @(posedge clk);
        cfg_index <= CFG_COLS;
        cfg_data  <= {10'($urandom_range(0, 1023)), cols};
        @(posedge clk);
        cfg_index <= CFG_SEED;
        cfg_data  <= seed;
        @(posedge clk);
        cfg_we   <= 1'b0;
        rows_now = (rows < GRID_MAX) ? rows : GRID_MAX;
        cols_now = (cols < GRID_MAX) ? cols : GRID_MAX;
    endtask

    initial
    begin : stimulus
        int unsigned r;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Reset contents, then a full-size maze from the far corner
        send(REQ_READ, 0, 0);
        send(REQ_READ, 31, 31);
        send(REQ_GEN, 31, 31);
        send(REQ_READ, 0, 16);
        send(REQ_READ, 31, 31);
        send(REQ_READ, 0, 0);
        send(REQ_READ, 16, 5);

        // Oversized rows, zero seed; a rejected generate keeps the old maze
        write_regs(6'd63, 6'd4, 16'h0000);
        send(REQ_GEN, 0, 4);
        send(REQ_READ, 0, 0);
        send(REQ_READ, 31, 3);
        send(REQ_GEN, 5, 2);
        send(REQ_READ, 5, 2);
        send(REQ_READ, 0, 2);
        send(REQ_READ, 31, 3);

        // Empty grid rejects everything
        write_regs(6'd0, 6'd32, 16'hFFFF);
        send(REQ_GEN, 0, 0);
        send(REQ_READ, 0, 0);
        write_regs(6'd32, 6'd0, 16'h0001);
        send(REQ_GEN, 31, 0);

        // Single cell grid
        write_regs(6'd1, 6'd1, 16'h0001);
        send(REQ_GEN, 0, 0);
        send(REQ_READ, 0, 0);
        send(REQ_READ, 0, 1);
        send(REQ_READ, 1, 0);

        // Single row, full width
        write_regs(6'd1, 6'd32, 16'hFFFF);
        send(REQ_GEN, 0, 31);
        send(REQ_READ, 0, 16);
        send(REQ_READ, 0, 31);

        // Random settings: a maze, then mostly reads with some regenerates and strays
        for (int p = 0; p < 10; p++)
        begin
            write_regs(pick_size(), pick_size(), pick_seed());
            send(REQ_GEN, pick_coord(rows_now), pick_coord(cols_now));
            for (int n = 0; n < 11; n++)
            begin
                r = $urandom_range(0, 99);
                if (r < 4)
                    drain();
                if (r < 12)
                    send(REQ_GEN, pick_coord(rows_now), pick_coord(cols_now));
                else if (r < 22)
                    send(req_kind_t'($urandom_range(0, 1)), $urandom_range(0, 31),
                         $urandom_range(0, 31));
                else
                    send(REQ_READ, pick_coord(rows_now), pick_coord(cols_now));
            end
        end

        // Let the last result land and make sure nothing stray follows
        drain();
        repeat (16) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Hang guard
    initial
    begin
        #100_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
